[sv/imhq_pkg.sv]
// Package for the indexed min-heap queue: function, status codes and queue entry types.
// No dependencies.
package imhq_pkg;
   localparam int HANDLE_BITS = 10;
   localparam int IN_KEY_BITS = 32;
   localparam int COUNT_BITS  = 11;
   localparam int STATUS_BITS = 2;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_ABSENT = 2'd2
   } status_type;

   // Command passed from the front end to the heap engine.
   typedef struct packed {
      func_type                 func;
      logic [HANDLE_BITS-1:0]   handle;
      logic [IN_KEY_BITS-1:0]   key;
   } cmd_type;
endpackage

[sv/imhq_if.sv]
// Valid/ready channel interfaces for the indexed min-heap queue.
// Depends on imhq_pkg.
interface imhq_req_if;
   import imhq_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   func;
   logic [HANDLE_BITS-1:0] handle;
   logic [IN_KEY_BITS-1:0] key;
   modport source (output valid, func, handle, key, input ready);
   modport sink   (input valid, func, handle, key, output ready);
endinterface

interface imhq_rsp_if;
   import imhq_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [COUNT_BITS-1:0]  item_count;
   logic [HANDLE_BITS-1:0] top_handle;
   logic [IN_KEY_BITS-1:0] top_key;
   logic                   is_empty;
   modport source (output valid, status, item_count, top_handle, top_key, is_empty,
                   input ready);
   modport sink   (input valid, status, item_count, top_handle, top_key, is_empty,
                   output ready);
endinterface

[sv/imhq_front.sv]
// Front end: takes request items into a two-entry command queue.
// Depends on imhq_pkg.
module imhq_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  imhq_pkg::cmd_type  in_cmd,
   output logic               out_valid,
   input  logic               out_ready,
   output imhq_pkg::cmd_type  out_cmd
);
   import imhq_pkg::*;

   cmd_type q_ff [2];
   logic    rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] fill_ff, fill_in;

   assign in_ready  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_cmd   = q_ff[rd_ff];

   always_comb begin
      rd_in = rd_ff;
      wr_in = wr_ff;
      fill_in = fill_ff;
      if (in_valid && in_ready) begin
         wr_in = ~wr_ff;
         fill_in = fill_in + 2'd1;
      end
      if (out_valid && out_ready) begin
         rd_in = ~rd_ff;
         fill_in = fill_in - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         fill_ff <= fill_in;
      end
      if (in_valid && in_ready) q_ff[wr_ff] <= in_cmd;
   end
endmodule

[sv/imhq_engine.sv]
// Heap engine: heap array, handle table and sift sequencer with a result register.
// Depends on imhq_pkg.
module imhq_engine #(
   parameter int CAPACITY = 1024,
   parameter int KEY_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_valid,
   output logic                           cmd_ready,
   input  imhq_pkg::cmd_type              cmd,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [imhq_pkg::STATUS_BITS-1:0] rsp_status,
   output logic [imhq_pkg::COUNT_BITS-1:0]  rsp_count,
   output logic [imhq_pkg::HANDLE_BITS-1:0] rsp_handle,
   output logic [imhq_pkg::IN_KEY_BITS-1:0] rsp_key,
   output logic                           rsp_empty
);
   import imhq_pkg::*;

   localparam int PB = $clog2(CAPACITY);
   localparam int CB = $clog2(CAPACITY + 1);
   localparam int HS = 1 << HANDLE_BITS;
   localparam int KC = (KEY_BITS < IN_KEY_BITS) ? KEY_BITS : IN_KEY_BITS;

   typedef enum logic [4:0] {
      S_IDLE, S_LOOK, S_LOOK_W, S_INS_NEW, S_DUP, S_RM_LAST, S_RM_LAST_W, S_RM_MOVE,
      S_UP_RD, S_UP_W, S_UP_CMP, S_DN_RD, S_DN_W, S_DN_CMP, S_TOP, S_TOP_W, S_DONE,
      S_CLEAR
   } state_type;

   // memories
   logic [HANDLE_BITS-1:0] mem_h [CAPACITY];
   logic [KEY_BITS-1:0]    mem_k [CAPACITY];
   logic [PB-1:0]          mem_pos [HS];
   logic                   mem_present [HS];

   state_type              st_ff;
   cmd_type                c_ff;
   logic [CB-1:0]          cnt_ff;
   logic [PB-1:0]          p_ff, b_ff;
   logic [HANDLE_BITS-1:0] ph_ff;
   logic [KEY_BITS-1:0]    pk_ff;
   logic                   up_done_ff;
   logic [STATUS_BITS-1:0] st_code_ff;
   logic                   second_ff;
   logic [HANDLE_BITS-1:0] clr_ff;

   // read ports, registered data
   logic [PB-1:0] ra_ff, rb_ff;
   logic [HANDLE_BITS-1:0] rha_ff, rhb_ff;
   logic [KEY_BITS-1:0]    rka_ff, rkb_ff;
   logic [HANDLE_BITS-1:0] pos_ra;
   logic [PB-1:0]          pos_rd_ff;
   logic                   pres_rd_ff;
   // write ports
   logic                   hw_en;
   logic [PB-1:0]          hw_a;
   logic [HANDLE_BITS-1:0] hw_h;
   logic [KEY_BITS-1:0]    hw_k;
   logic                   pw_en;
   logic [HANDLE_BITS-1:0] pw_a;
   logic [PB-1:0]          pw_d;
   logic                   pr_en;
   logic [HANDLE_BITS-1:0] pr_a;
   logic                   pr_d;

   logic [CB:0]   l_w, r_w;
   logic          r_ok;
   logic [PB-1:0] par;
   logic          rm_ok;
   // smaller child, left on a tie
   logic                   dn_right;
   logic [HANDLE_BITS-1:0] ch_h;
   logic [KEY_BITS-1:0]    ch_k;
   logic [PB-1:0]          ch_a;
   logic                   up_swap, dn_swap;

   assign cmd_ready = (st_ff == S_IDLE);
   assign par = PB'((p_ff - 1'b1) >> 1);
   assign l_w = (CB+1)'({p_ff, 1'b1});
   assign r_w = l_w + (CB+1)'(1);
   assign rm_ok = pres_rd_ff && ({1'b0, pos_rd_ff} < cnt_ff);

   assign dn_right = (rkb_ff < rka_ff) && (rb_ff != ra_ff);
   assign ch_h = dn_right ? rhb_ff : rha_ff;
   assign ch_k = dn_right ? rkb_ff : rka_ff;
   assign ch_a = dn_right ? rb_ff : ra_ff;
   assign up_swap = (pk_ff < rka_ff);
   assign dn_swap = (ch_k < pk_ff);

   always_ff @(posedge clock) begin
      rha_ff <= mem_h[ra_ff];
      rka_ff <= mem_k[ra_ff];
      rhb_ff <= mem_h[rb_ff];
      rkb_ff <= mem_k[rb_ff];
      pos_rd_ff <= mem_pos[pos_ra];
      pres_rd_ff <= mem_present[pos_ra];
      if (hw_en) begin
         mem_h[hw_a] <= hw_h;
         mem_k[hw_a] <= hw_k;
      end
      if (pw_en) mem_pos[pw_a] <= pw_d;
      if (pr_en) mem_present[pr_a] <= pr_d;
   end

   assign pos_ra = c_ff.handle;

   // one heap write per cycle: the other entry lands at p_ff, the moving one at b_ff next
   always_comb begin
      hw_en = 1'b0; hw_a = p_ff; hw_h = ph_ff; hw_k = pk_ff;
      pw_en = 1'b0; pw_a = ph_ff; pw_d = p_ff;
      pr_en = 1'b0; pr_a = c_ff.handle; pr_d = 1'b0;
      r_ok = (r_w < ({1'b0, cnt_ff}));
      case (st_ff)
         S_CLEAR: begin
            pr_en = 1'b1; pr_a = clr_ff;
         end
         S_LOOK_W: begin
            if (c_ff.func == FUNC_REMOVE && rm_ok) pr_en = 1'b1;
         end
         S_INS_NEW: begin
            hw_en = 1'b1; hw_a = PB'(cnt_ff);
            pw_en = 1'b1; pw_d = PB'(cnt_ff);
            pr_en = 1'b1; pr_d = 1'b1;
         end
         S_DUP, S_RM_MOVE: begin
            hw_en = 1'b1; pw_en = 1'b1;
         end
         S_UP_CMP: begin
            if (second_ff) begin
               hw_en = 1'b1; hw_a = b_ff;
               pw_en = 1'b1; pw_d = b_ff;
            end else if (up_swap) begin
               hw_en = 1'b1; hw_h = rha_ff; hw_k = rka_ff;
               pw_en = 1'b1; pw_a = rha_ff;
            end
         end
         S_DN_CMP: begin
            if (second_ff) begin
               hw_en = 1'b1; hw_a = b_ff;
               pw_en = 1'b1; pw_d = b_ff;
            end else if (dn_swap) begin
               hw_en = 1'b1; hw_h = ch_h; hw_k = ch_k;
               pw_en = 1'b1; pw_a = ch_h;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR;
         clr_ff <= '0;
         cnt_ff <= '0;
         rsp_valid <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         case (st_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == '1) st_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (cmd_valid) begin
                  c_ff <= cmd;
                  st_ff <= S_LOOK;
               end
            end
            S_LOOK: st_ff <= S_LOOK_W;
            S_LOOK_W: begin
               ph_ff <= c_ff.handle;
               pk_ff <= KEY_BITS'(c_ff.key[KC-1:0]);
               if (c_ff.func == FUNC_INSERT) begin
                  if (cnt_ff >= CB'(CAPACITY)) begin
                     st_code_ff <= STATUS_FULL; st_ff <= S_TOP;
                  end else if (pres_rd_ff) begin
                     st_code_ff <= STATUS_OK; p_ff <= pos_rd_ff; st_ff <= S_DUP;
                  end else begin
                     st_code_ff <= STATUS_OK; st_ff <= S_INS_NEW;
                  end
               end else if (!rm_ok) begin
                  st_code_ff <= STATUS_ABSENT; st_ff <= S_TOP;
               end else begin
                  st_code_ff <= STATUS_OK;
                  p_ff <= pos_rd_ff;
                  cnt_ff <= cnt_ff - 1'b1;
                  if ({1'b0, pos_rd_ff} == cnt_ff - 1'b1) st_ff <= S_TOP;
                  else begin
                     ra_ff <= PB'(cnt_ff - 1'b1);
                     st_ff <= S_RM_LAST;
                  end
               end
            end
            S_INS_NEW: begin
               p_ff <= PB'(cnt_ff);
               cnt_ff <= cnt_ff + 1'b1;
               up_done_ff <= 1'b1;
               st_ff <= S_UP_RD;
            end
            S_DUP: begin up_done_ff <= 1'b0; st_ff <= S_UP_RD; end
            S_RM_LAST: st_ff <= S_RM_LAST_W;
            S_RM_LAST_W: begin
               ph_ff <= rha_ff; pk_ff <= rka_ff; st_ff <= S_RM_MOVE;
            end
            S_RM_MOVE: begin up_done_ff <= 1'b0; st_ff <= S_UP_RD; end
            S_UP_RD: begin
               if (p_ff == '0) st_ff <= up_done_ff ? S_TOP : S_DN_RD;
               else begin ra_ff <= par; st_ff <= S_UP_W; end
            end
            S_UP_W: st_ff <= S_UP_CMP;
            S_UP_CMP: begin
               if (second_ff) begin
                  second_ff <= 1'b0; p_ff <= b_ff; st_ff <= S_UP_RD;
               end else if (up_swap) begin
                  b_ff <= ra_ff; second_ff <= 1'b1;
               end else st_ff <= up_done_ff ? S_TOP : S_DN_RD;
            end
            S_DN_RD: begin
               if (l_w >= {1'b0, cnt_ff}) st_ff <= S_TOP;
               else begin
                  ra_ff <= PB'(l_w);
                  rb_ff <= r_ok ? PB'(r_w) : PB'(l_w);
                  st_ff <= S_DN_W;
               end
            end
            S_DN_W: st_ff <= S_DN_CMP;
            S_DN_CMP: begin
               if (second_ff) begin
                  second_ff <= 1'b0; p_ff <= b_ff; st_ff <= S_DN_RD;
               end else if (dn_swap) begin
                  b_ff <= ch_a; second_ff <= 1'b1;
               end else st_ff <= S_TOP;
            end
            S_TOP: begin ra_ff <= '0; st_ff <= S_TOP_W; end
            S_TOP_W: st_ff <= S_DONE;
            S_DONE: begin
               if (!rsp_valid || rsp_ready) begin
                  rsp_valid <= 1'b1;
                  rsp_status <= st_code_ff;
                  rsp_count <= COUNT_BITS'(cnt_ff);
                  rsp_empty <= (cnt_ff == '0);
                  rsp_handle <= (cnt_ff == '0) ? '0 : rha_ff;
                  rsp_key <= (cnt_ff == '0) ? '0 : IN_KEY_BITS'(rka_ff);
                  st_ff <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
         if (rsp_valid && rsp_ready && st_ff != S_DONE) rsp_valid <= 1'b0;
      end
   end
endmodule

[sv/indexed_min_heap_queue_top.sv]
// Top level of the indexed min-heap queue: front queue plus heap engine.
// Depends on imhq_pkg, imhq_if, imhq_front, imhq_engine.
//
// Binary min-heap of up to CAPACITY items keyed by unsigned KEY_BITS keys, with a
// handle-to-slot table so items can be removed by handle. Each request item gives
// one response item: status, count and the current top. Each heap level walked
// takes registered reads (the parent going up, both children going down) and a
// compare, then two writes through the one write port of the heap arrays. An item
// may also wait for its response to be taken. A two-entry queue in front takes
// items while the engine works. After reset the engine clears all 1024 entries of
// the presence table before it takes the first item.
module indexed_min_heap_queue_top #(
   parameter int CAPACITY = 1024,
   parameter int KEY_BITS = 32
) (
   input logic clock,
   input logic reset,
   imhq_req_if.sink   req,
   imhq_rsp_if.source rsp
);
   import imhq_pkg::*;

   cmd_type in_cmd, q_cmd;
   logic    q_valid, q_ready;

   assign in_cmd.func   = func_type'(req.func);
   assign in_cmd.handle = req.handle;
   assign in_cmd.key    = req.key;

   imhq_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_cmd(in_cmd),
      .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
   );

   imhq_engine #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_engine (
      .clock, .reset,
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_status(rsp.status), .rsp_count(rsp.item_count),
      .rsp_handle(rsp.top_handle), .rsp_key(rsp.top_key), .rsp_empty(rsp.is_empty)
   );

   // empty flag agrees with count
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.is_empty == (rsp.item_count == '0))) else $error("empty flag");
   // count never exceeds capacity
   a_cap: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.item_count <= COUNT_BITS'(CAPACITY))) else $error("count");
endmodule

[verif/imhq_tb_if.sv]
`timescale 1ns / 1ps
// Testbench package: type of a pending request item for the driver queue.
// Depends on imhq_pkg.
package imhq_tb_pkg;
   import imhq_pkg::*;
   typedef struct {
      func_type               func;
      logic [HANDLE_BITS-1:0] handle;
      logic [IN_KEY_BITS-1:0] key;
      int                     gap;
   } req_item_type;
endpackage

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for indexed_min_heap_queue_top: random and directed
// insert/remove traffic checked against an in-bench heap predictor.
// Depends on imhq_pkg, imhq_tb_pkg, imhq_if and the RTL.
module testbench;
   import imhq_pkg::*;
   import imhq_tb_pkg::*;

   localparam int CAP       = 1024;
   localparam int LIMIT_CYC = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   imhq_req_if req ();
   imhq_rsp_if rsp ();

   indexed_min_heap_queue_top #(.CAPACITY(CAP), .KEY_BITS(32)) DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp)
   );

   // Expected response fields
   typedef struct {
      status_type             status;
      logic [COUNT_BITS-1:0]  item_count;
      logic [HANDLE_BITS-1:0] top_handle;
      logic [IN_KEY_BITS-1:0] top_key;
      logic                   is_empty;
   } heap_rsp_type;

   // Predictor state: heap array plus handle table
   logic [HANDLE_BITS-1:0] hp_handle [CAP];
   logic [IN_KEY_BITS-1:0] hp_key [CAP];
   int                     hp_pos [1024];
   bit                     hp_present [1024];
   int                     hp_count = 0;

   req_item_type pending_reqs[$];
   heap_rsp_type expected_rsps[$];
   int        errors = 0;
   int        cycles = 0;
   int        rsp_seen = 0;
   int        full_seen = 0;
   int        absent_seen = 0;
   bit        hold_rsp = 1'b0;    // long receiver stall window
   bit        drain_wait = 1'b0;  // sender pause until all responses return

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void swap_slots(input int a, input int b);
      logic [HANDLE_BITS-1:0] h;
      logic [IN_KEY_BITS-1:0] k;
      begin
         h = hp_handle[a]; k = hp_key[a];
         hp_handle[a] = hp_handle[b]; hp_key[a] = hp_key[b];
         hp_handle[b] = h; hp_key[b] = k;
         hp_pos[hp_handle[a]] = a;
         hp_pos[hp_handle[b]] = b;
      end
   endfunction

   function automatic int sift_up(input int p);
      int par;
      begin
         while (p > 0 && p < hp_count) begin
            par = (p - 1) / 2;
            if (!(hp_key[p] < hp_key[par])) break;
            swap_slots(p, par);
            p = par;
         end
         return p;
      end
   endfunction

   task automatic sift_down(input int p);
      int l, c;
      begin
         while (p < hp_count) begin
            l = 2 * p + 1;
            if (l >= hp_count) break;
            c = l;
            // left child wins ties
            if (l + 1 < hp_count && hp_key[l+1] < hp_key[l]) c = l + 1;
            if (!(hp_key[c] < hp_key[p])) break;
            swap_slots(p, c);
            p = c;
         end
      end
   endtask

   // Apply one request item to the predictor and queue its response
   task automatic predict_heap_op(input req_item_type it);
      heap_rsp_type r;
      int p;
      begin
         r.status = STATUS_OK;
         if (it.func == FUNC_INSERT) begin
            if (hp_count >= CAP) r.status = STATUS_FULL;
            else if (hp_present[it.handle]) begin
               // rekey in place
               p = hp_pos[it.handle];
               hp_key[p] = it.key;
               p = sift_up(p);
               sift_down(p);
            end else begin
               p = hp_count;
               hp_handle[p] = it.handle;
               hp_key[p] = it.key;
               hp_pos[it.handle] = p;
               hp_present[it.handle] = 1'b1;
               hp_count++;
               p = sift_up(p);
            end
         end else begin
            if (!hp_present[it.handle]) r.status = STATUS_ABSENT;
            else begin
               p = hp_pos[it.handle];
               hp_present[it.handle] = 1'b0;
               hp_count--;
               if (p != hp_count) begin
                  // last entry fills the hole, may go either way
                  hp_handle[p] = hp_handle[hp_count];
                  hp_key[p] = hp_key[hp_count];
                  hp_pos[hp_handle[p]] = p;
                  p = sift_up(p);
                  sift_down(p);
               end
            end
         end
         r.item_count = hp_count[COUNT_BITS-1:0];
         r.is_empty = (hp_count == 0);
         r.top_handle = (hp_count > 0) ? hp_handle[0] : '0;
         r.top_key = (hp_count > 0) ? hp_key[0] : '0;
         expected_rsps.push_back(r);
      end
   endtask

   function automatic req_item_type mk(input func_type f, input int h, input logic [31:0] k);
      req_item_type it;
      begin
         it.func = f; it.handle = h[HANDLE_BITS-1:0]; it.key = k;
         it.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         return it;
      end
   endfunction

   // Driver: one item in flight on the request channel
   int  req_wait;
   bit  req_have;
   req_item_type req_cur;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.func <= FUNC_INSERT;
         req.handle <= '0;
         req.key <= '0;
         req_have = 1'b0;
         req_wait = 0;
      end else begin
         if (req.valid && req.ready) begin
            predict_heap_op(req_cur);
            req_have = 1'b0;
         end
         if (!req_have && pending_reqs.size() > 0 && pending_reqs[0].gap < 0) begin
            // marker: pause until all responses are back
            drain_wait = (expected_rsps.size() != 0);
            if (!drain_wait) void'(pending_reqs.pop_front());
         end
         if (!req_have && pending_reqs.size() > 0 && pending_reqs[0].gap >= 0) begin
            req_cur = pending_reqs.pop_front();
            req_have = 1'b1;
            req_wait = req_cur.gap;
         end
         if (req_have && req_wait == 0) begin
            req.valid <= 1'b1;
            req.func <= req_cur.func;
            req.handle <= req_cur.handle;
            req.key <= req_cur.key;
         end else begin
            req.valid <= 1'b0;
            if (req_have) req_wait--;
         end
      end
   end

   // Monitor: receiver with random stalls and one long hold-off
   int rsp_wait;
   int hold_cnt;
   heap_rsp_type exp_r;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         rsp_wait = 0;
         hold_cnt = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            rsp_seen++;
            if (rsp.status == STATUS_FULL) full_seen++;
            if (rsp.status == STATUS_ABSENT) absent_seen++;
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("%0t: unexpected response status=%0d count=%0d", $time,
                        rsp.status, rsp.item_count);
            end else begin
               exp_r = expected_rsps.pop_front();
               if (rsp.status !== exp_r.status || rsp.item_count !== exp_r.item_count ||
                   rsp.top_handle !== exp_r.top_handle || rsp.top_key !== exp_r.top_key ||
                   rsp.is_empty !== exp_r.is_empty) begin
                  errors++;
                  $display("%0t: mismatch exp st=%0d cnt=%0d h=%0d k=%h e=%0d", $time,
                           exp_r.status, exp_r.item_count, exp_r.top_handle,
                           exp_r.top_key, exp_r.is_empty);
                  $display("%0t:          got st=%0d cnt=%0d h=%0d k=%h e=%0d", $time,
                           rsp.status, rsp.item_count, rsp.top_handle, rsp.top_key,
                           rsp.is_empty);
               end
            end
            rsp_wait = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
         end
         if (hold_rsp && hold_cnt < 400) begin
            hold_cnt++;
            rsp.ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // Cycle limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYC) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic req_item_type pause_marker();
      req_item_type it;
      begin
         it.func = FUNC_INSERT; it.handle = '0; it.key = '0; it.gap = -1;
         return it;
      end
   endfunction

   initial begin : stimulus
      int i, h;
      logic [31:0] k;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty remove, extremes, ties, rekey, remove of top and last
      pending_reqs.push_back(mk(FUNC_REMOVE, 0, 32'h0));
      pending_reqs.push_back(mk(FUNC_INSERT, 1023, 32'hFFFF_FFFF));
      pending_reqs.push_back(mk(FUNC_INSERT, 0, 32'h0));
      pending_reqs.push_back(mk(FUNC_INSERT, 5, 32'h0));
      pending_reqs.push_back(mk(FUNC_INSERT, 6, 32'h0001_0000));
      pending_reqs.push_back(mk(FUNC_INSERT, 7, 32'h0001_0000));
      pending_reqs.push_back(mk(FUNC_INSERT, 5, 32'hFFFF_FFFE));
      pending_reqs.push_back(mk(FUNC_INSERT, 1023, 32'h0));
      pending_reqs.push_back(mk(FUNC_REMOVE, 0, 32'hFFFF_FFFF));
      pending_reqs.push_back(mk(FUNC_REMOVE, 0, 32'h0));
      pending_reqs.push_back(mk(FUNC_REMOVE, 7, 32'h0));
      pending_reqs.push_back(mk(FUNC_REMOVE, 512, 32'h0));
      pending_reqs.push_back(mk(FUNC_REMOVE, 1023, 32'h0));
      pending_reqs.push_back(mk(FUNC_REMOVE, 6, 32'h0));
      pending_reqs.push_back(mk(FUNC_REMOVE, 5, 32'h0));
      pending_reqs.push_back(pause_marker());

      // Random mix over a small handle pool, deep heap churn
      for (i = 0; i < 150; i++) begin
         h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 63);
         k = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : $urandom;
         pending_reqs.push_back(mk(($urandom_range(0, 9) < 6) ? FUNC_INSERT : FUNC_REMOVE,
                                   h, k));
         if (i == 50) pending_reqs.push_back(pause_marker());
      end
      pending_reqs.push_back(pause_marker());
      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);

      // Fill to capacity with back-to-back items, then overflow attempts
      for (i = 0; i < 1024; i++) begin
         k = $urandom;
         pending_reqs.push_back(mk(FUNC_INSERT, i, k));
         pending_reqs[$].gap = 0;
      end
      for (i = 0; i < 6; i++) pending_reqs.push_back(mk(FUNC_INSERT, $urandom_range(0, 1023),
                                                       $urandom));
      // Receiver holds off while the sender keeps offering
      hold_rsp = 1;
      for (i = 0; i < 100; i++)
         pending_reqs.push_back(mk(FUNC_REMOVE, $urandom_range(0, 1023), 32'h0));
      for (i = 0; i < 100; i++)
         pending_reqs.push_back(mk(($urandom_range(0, 1) == 0) ? FUNC_INSERT : FUNC_REMOVE,
                                   $urandom_range(0, 1023), $urandom));

      wait (pending_reqs.size() == 0 && !req.valid);
      wait (expected_rsps.size() == 0);
      repeat (200) @(posedge clock);
      $display("Covered %0d responses: %0d full, %0d absent-handle, heap filled to %0d.",
               rsp_seen, full_seen, absent_seen, CAP);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Errors: %0d", errors);
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

[indexed_min_heap_queue_top.f]
sv/imhq_pkg.sv
sv/imhq_if.sv
sv/imhq_front.sv
sv/imhq_engine.sv
sv/indexed_min_heap_queue_top.sv
verif/imhq_tb_if.sv
verif/testbench.sv
